[rtl/fov_pkg.sv]
// ----------------------------------------------------------------------------
// fov_pkg
// Shared widths, angle constants, arctangent table and register codes for the
// conical field-of-view margin block.
// ----------------------------------------------------------------------------
package fov_pkg;

  localparam int ANGLE_FRAC_BITS = 13;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam longint ANG_PI =
    longint'((PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS));
  localparam longint ANG_TWO_PI =
    longint'((PI_Q60 + (64'd1 << (58 - ANGLE_FRAC_BITS))) >> (59 - ANGLE_FRAC_BITS));

  localparam int CONE_W   = ANGLE_FRAC_BITS + 2;
  localparam int CLOCK_W  = ANGLE_FRAC_BITS + 3;
  localparam int MARGIN_W = ANGLE_FRAC_BITS + 4;
  localparam int ACC_W    = ANGLE_FRAC_BITS + 4;
  localparam int WIDE_W   = ANGLE_FRAC_BITS + 6;
  localparam int CORDIC_W = 64;
  localparam int CORDIC_GUARD_TOTAL = 60;
  localparam int MAX_STAGES = 32;

  // atan(2^-i) in radians Q.13, rounded half up
  localparam logic [ACC_W-1:0] ATAN_TAB [MAX_STAGES] = '{
    17'd6434, 17'd3798, 17'd2007, 17'd1019, 17'd511, 17'd256, 17'd128, 17'd64,
    17'd32,   17'd16,   17'd8,    17'd4,    17'd2,   17'd1,   17'd0,   17'd0,
    17'd0,    17'd0,    17'd0,    17'd0,    17'd0,   17'd0,   17'd0,   17'd0,
    17'd0,    17'd0,    17'd0,    17'd0,    17'd0,   17'd0,   17'd0,   17'd0
  };

  typedef enum logic [1:0] {
    REG_INNER_CONE = 2'd0,
    REG_OUTER_CONE = 2'd1,
    REG_MIN_CLOCK  = 2'd2,
    REG_MAX_CLOCK  = 2'd3
  } cfg_reg_t;

endpackage

[rtl/fov_dir_if.sv]
// ----------------------------------------------------------------------------
// fov_dir_if
// Valid/ready channel carrying one sensor-frame direction vector.
// ----------------------------------------------------------------------------
interface fov_dir_if #(
  parameter int CW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] dir_x;
  logic signed [CW-1:0] dir_y;
  logic signed [CW-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

[rtl/fov_margin_if.sv]
// ----------------------------------------------------------------------------
// fov_margin_if
// Valid/ready channel carrying one angular margin result.
// ----------------------------------------------------------------------------
interface fov_margin_if;
  import fov_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [MARGIN_W-1:0] margin;

  modport source (output valid, output margin, input ready);
  modport sink   (input valid, input margin, output ready);
endinterface

[rtl/fov_isqrt.sv]
// ----------------------------------------------------------------------------
// fov_isqrt
// Pipelined floor square root of x^2 + y^2, one root bit per stage.
// ----------------------------------------------------------------------------
module fov_isqrt #(
  parameter int CW     = 16,
  parameter int SIDE_W = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] x,
  input  logic signed [CW-1:0] y,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 out_valid,
  output logic [CW-1:0]        root,
  output logic [SIDE_W-1:0]    side_out
);
  localparam int RW = 2 * CW;

  logic signed [RW-1:0] xx;
  logic signed [RW-1:0] yy;
  logic [RW-1:0]        xx_q;
  logic [RW-1:0]        yy_q;
  logic [SIDE_W-1:0]    side0_q;
  logic                 v0_q;

  logic [RW-1:0]     n_q    [CW+1];
  logic [RW-1:0]     r_q    [CW+1];
  logic [SIDE_W-1:0] side_q [CW+1];
  logic              v_q    [CW+1];

  assign xx = x * x;
  assign yy = y * y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0_q   <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (en) begin
      v0_q   <= in_valid;
      v_q[0] <= v0_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_q      <= xx;
      yy_q      <= yy;
      side0_q   <= side_in;
      n_q[0]    <= xx_q + yy_q;
      r_q[0]    <= '0;
      side_q[0] <= side0_q;
    end
  end

  for (genvar j = 0; j < CW; j++) begin : g_digit
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (CW - 1 - j));
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = r_q[j] + BIT;
    assign ge    = n_q[j] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j+1] <= 1'b0;
      end else if (en) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[j+1]    <= ge ? n_q[j] - trial : n_q[j];
        r_q[j+1]    <= ge ? (r_q[j] >> 1) + BIT : r_q[j] >> 1;
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign out_valid = v_q[CW];
  assign root      = r_q[CW][CW-1:0];
  assign side_out  = side_q[CW];

endmodule

[rtl/fov_cordic.sv]
// ----------------------------------------------------------------------------
// fov_cordic
// Pipelined vectoring CORDIC computing atan2(b, a) in radians Q.13,
// one rotation per stage, clamped to [-pi, pi].
// ----------------------------------------------------------------------------
module fov_cordic #(
  parameter int IW     = 17,
  parameter int GUARD  = 44,
  parameter int STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [IW-1:0]                b,
  input  logic signed [IW-1:0]                a,
  output logic                                out_valid,
  output logic signed [fov_pkg::ACC_W-1:0]    angle
);
  import fov_pkg::*;

  localparam int DW = CORDIC_W;
  localparam logic signed [ACC_W-1:0] PI_A = ACC_W'(ANG_PI);

  logic                   fixed;
  logic                   a_neg;
  logic signed [IW:0]     a_n;
  logic signed [IW:0]     b_n;
  logic signed [ACC_W-1:0] acc0;

  logic signed [DW-1:0]    xs_q  [STAGES+1];
  logic signed [DW-1:0]    ys_q  [STAGES+1];
  logic signed [ACC_W-1:0] acc_q [STAGES+1];
  logic                    fix_q [STAGES+1];
  logic                    v_q   [STAGES+1];
  logic                    v_out_q;
  logic signed [ACC_W-1:0] angle_q;

  always_comb begin
    fixed = (b == '0);
    a_neg = a[IW-1];
    a_n   = a_neg ? -{a[IW-1], a} : {a[IW-1], a};
    b_n   = a_neg ? -{b[IW-1], b} : {b[IW-1], b};
    if (fixed) begin
      acc0 = a_neg ? PI_A : '0;
    end else if (a_neg) begin
      acc0 = b[IW-1] ? -PI_A : PI_A;
    end else begin
      acc0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs_q[0]  <= {{(DW-IW-1){a_n[IW]}}, a_n} <<< GUARD;
      ys_q[0]  <= {{(DW-IW-1){b_n[IW]}}, b_n} <<< GUARD;
      acc_q[0] <= acc0;
      fix_q[0] <= fixed;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    logic signed [DW-1:0]    dx;
    logic signed [DW-1:0]    dy;
    logic signed [ACC_W-1:0] t;
    logic                    up;

    assign dx = ys_q[i] >>> i;
    assign dy = xs_q[i] >>> i;
    assign t  = ATAN_TAB[i];
    assign up = ys_q[i] > 0;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i+1] <= 1'b0;
      end else if (en) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs_q[i+1]  <= up ? xs_q[i] + dx : xs_q[i] - dx;
        ys_q[i+1]  <= up ? ys_q[i] - dy : ys_q[i] + dy;
        fix_q[i+1] <= fix_q[i];
        if (fix_q[i]) begin
          acc_q[i+1] <= acc_q[i];
        end else begin
          acc_q[i+1] <= up ? acc_q[i] + t : acc_q[i] - t;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out_q <= 1'b0;
    end else if (en) begin
      v_out_q <= v_q[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (acc_q[STAGES] > PI_A) begin
        angle_q <= PI_A;
      end else if (acc_q[STAGES] < -PI_A) begin
        angle_q <= -PI_A;
      end else begin
        angle_q <= acc_q[STAGES];
      end
    end
  end

  assign out_valid = v_out_q;
  assign angle     = angle_q;

endmodule

[rtl/fov_margin.sv]
// ----------------------------------------------------------------------------
// fov_margin
// Folds the clock angle, forms cone and clock-window margins, takes the
// smallest and saturates; the last stage is the output register.
// ----------------------------------------------------------------------------
module fov_margin (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [fov_pkg::ACC_W-1:0]     cone_ang,
  input  logic signed [fov_pkg::ACC_W-1:0]     clock_ang,
  input  logic [fov_pkg::CONE_W-1:0]           inner,
  input  logic [fov_pkg::CONE_W-1:0]           outer,
  input  logic [fov_pkg::CLOCK_W-1:0]          cmin,
  input  logic [fov_pkg::CLOCK_W-1:0]          cmax,
  output logic                                 out_valid,
  output logic signed [fov_pkg::MARGIN_W-1:0]  margin
);
  import fov_pkg::*;

  localparam logic signed [WIDE_W-1:0] TWO_PI_W = WIDE_W'(ANG_TWO_PI);

  logic signed [WIDE_W-1:0] ang_w;
  logic signed [WIDE_W-1:0] clk_w;
  logic signed [WIDE_W-1:0] inner_w;
  logic signed [WIDE_W-1:0] outer_w;
  logic signed [WIDE_W-1:0] min_w;
  logic signed [WIDE_W-1:0] max_w;
  logic signed [WIDE_W-1:0] to_min;
  logic signed [WIDE_W-1:0] to_max;
  logic signed [WIDE_W-1:0] cm;

  logic signed [WIDE_W-1:0] lo_q;
  logic signed [WIDE_W-1:0] hi_q;
  logic signed [WIDE_W-1:0] cm_q;
  logic                     va_q;

  logic signed [WIDE_W-1:0] m;
  logic signed [MARGIN_W-1:0] margin_q;
  logic                       vb_q;

  always_comb begin
    ang_w   = cone_ang[ACC_W-1] ? '0 : WIDE_W'(cone_ang);
    clk_w   = WIDE_W'(clock_ang);
    inner_w = WIDE_W'(inner);
    outer_w = WIDE_W'(outer);
    min_w   = WIDE_W'(cmin);
    max_w   = WIDE_W'(cmax);
    if (clk_w < 0) begin
      clk_w = clk_w + TWO_PI_W;
    end
    if (clk_w >= TWO_PI_W) begin
      clk_w = clk_w - TWO_PI_W;
    end
    to_min = '0;
    to_max = '0;
    if (min_w <= max_w) begin
      if (clk_w < min_w) begin
        cm = clk_w - min_w;
      end else if (clk_w > max_w) begin
        cm = max_w - clk_w;
      end else begin
        to_min = clk_w - min_w;
        to_max = max_w - clk_w;
        cm     = (to_min < to_max) ? to_min : to_max;
      end
    end else if (clk_w >= min_w || clk_w <= max_w) begin
      // wrapping window, inside: distances may run through zero
      to_min = (clk_w >= min_w) ? clk_w - min_w : (TWO_PI_W - min_w) + clk_w;
      to_max = (clk_w <= max_w) ? max_w - clk_w : max_w + (TWO_PI_W - clk_w);
      cm     = (to_min < to_max) ? to_min : to_max;
    end else begin
      to_min = min_w - clk_w;
      to_max = clk_w - max_w;
      cm     = (to_min < to_max) ? -to_min : -to_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid;
      vb_q <= va_q;
    end
  end

  always_comb begin
    m = (lo_q < hi_q) ? lo_q : hi_q;
    if (cm_q < m) begin
      m = cm_q;
    end
    if (m > TWO_PI_W) begin
      m = TWO_PI_W;
    end else if (m < -TWO_PI_W) begin
      m = -TWO_PI_W;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_q     <= ang_w - inner_w;
      hi_q     <= outer_w - ang_w;
      cm_q     <= cm;
      margin_q <= m[MARGIN_W-1:0];
    end
  end

  assign out_valid = vb_q;
  assign margin    = margin_q;

endmodule

[rtl/conical_fov_angular_margin.sv]
// ----------------------------------------------------------------------------
// conical_fov_angular_margin
// Angular margin of a direction vector against a complex conical field of
// view: inner/outer cone about +Z and a clock-angle window.
// ----------------------------------------------------------------------------
// throughput: one transfer per cycle while the result channel is not stalled;
//   depth is set by the square-root digit stages followed by the CORDIC rotation
//   stages, the two CORDICs run side by side
// a stall on the result channel freezes the whole pipeline
// reset clears all valid bits and loads the default field-of-view registers
module conical_fov_angular_margin #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  fov_pkg::cfg_reg_t             cfg_index,
  input  logic [fov_pkg::CLOCK_W-1:0]   cfg_data,
  fov_dir_if.sink                       dir,
  fov_margin_if.source                  result
);
  import fov_pkg::*;

  localparam int CW    = COMPONENT_WIDTH;
  localparam int IW    = CW + 1;
  localparam int GUARD = CORDIC_GUARD_TOTAL - CW;
  localparam int SW    = 3 * CW;

  logic [CONE_W-1:0]  inner_cone_angle;
  logic [CONE_W-1:0]  outer_cone_angle;
  logic [CLOCK_W-1:0] min_clock_angle;
  logic [CLOCK_W-1:0] max_clock_angle;

  logic                en;
  logic                sq_valid;
  logic [CW-1:0]       rho;
  logic [SW-1:0]       side;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic signed [CW-1:0] pz;

  logic                    cone_v;
  logic                    clock_v;
  logic signed [ACC_W-1:0] cone_ang;
  logic signed [ACC_W-1:0] clock_ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_cone_angle <= '0;
      outer_cone_angle <= CONE_W'(ANG_PI);
      min_clock_angle  <= '0;
      max_clock_angle  <= CLOCK_W'(ANG_TWO_PI);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INNER_CONE: inner_cone_angle <= cfg_data[CONE_W-1:0];
        REG_OUTER_CONE: outer_cone_angle <= cfg_data[CONE_W-1:0];
        REG_MIN_CLOCK:  min_clock_angle  <= cfg_data;
        REG_MAX_CLOCK:  max_clock_angle  <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: the output register frees up or is being taken
  assign en        = !result.valid || result.ready;
  assign dir.ready = en;

  fov_isqrt #(
    .CW     (CW),
    .SIDE_W (SW)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dir.valid),
    .x         (dir.dir_x),
    .y         (dir.dir_y),
    .side_in   ({dir.dir_x, dir.dir_y, dir.dir_z}),
    .out_valid (sq_valid),
    .root      (rho),
    .side_out  (side)
  );

  assign px = side[3*CW-1:2*CW];
  assign py = side[2*CW-1:CW];
  assign pz = side[CW-1:0];

  fov_cordic #(
    .IW     (IW),
    .GUARD  (GUARD),
    .STAGES (CORDIC_STAGES)
  ) u_cone (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .b         ({1'b0, rho}),
    .a         ({pz[CW-1], pz}),
    .out_valid (cone_v),
    .angle     (cone_ang)
  );

  fov_cordic #(
    .IW     (IW),
    .GUARD  (GUARD),
    .STAGES (CORDIC_STAGES)
  ) u_clock (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .b         ({py[CW-1], py}),
    .a         ({px[CW-1], px}),
    .out_valid (clock_v),
    .angle     (clock_ang)
  );

  fov_margin u_margin (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cone_v && clock_v),
    .cone_ang  (cone_ang),
    .clock_ang (clock_ang),
    .inner     (inner_cone_angle),
    .outer     (outer_cone_angle),
    .cmin      (min_clock_angle),
    .cmax      (max_clock_angle),
    .out_valid (result.valid),
    .margin    (result.margin)
  );

  // both angle pipelines stay in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (rst) cone_v == clock_v)
    else $error("cone and clock pipelines out of step");

  // result stays within the saturation range
  a_sat: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.margin <= MARGIN_W'(ANG_TWO_PI)) &&
                     (result.margin >= -MARGIN_W'(ANG_TWO_PI)))
    else $error("margin outside saturation range");

  // a stall freezes the angle stage
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(cone_ang) && $stable(clock_ang) && $stable(cone_v))
    else $error("pipeline moved during stall");

endmodule
